// ===== hdl/rsse_pkg.sv =====
package rsse_pkg;

    // GF(256) field polynomial x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [8:0] FIELD_POLY = 9'h11D;
    localparam int SYM_W = 8;
    localparam int MAX_NPAR = 255;

    typedef logic [SYM_W-1:0] sym_t;

    // Generator polynomial coefficients, index = power of x
    typedef logic [MAX_NPAR:0][SYM_W-1:0] gen_t;

    // Controller to datapath commands for one accepted item
    typedef struct packed {
        logic take;     // item accepted this cycle
        logic parity;   // item asks for the next parity octet
        logic last;     // that parity octet closes the codeword
    } cmd_t;

    // Output register occupancy
    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } state_t;

    // GF(256) product, shift-and-add with modular reduction
    function automatic sym_t gf_mul(input sym_t x, input sym_t y);
        logic [8:0] a;
        sym_t r;
        a = {1'b0, x};
        r = '0;
        for (int k = 0; k < SYM_W; k++)
        begin
            if (y[k])
            begin
                r = r ^ a[7:0];
            end
            a = {a[7:0], 1'b0};
            if (a[8])
            begin
                a = a ^ FIELD_POLY;
            end
        end
        return r;
    endfunction

    // g(x) = prod_{i=1..npar} (x + alpha^i), alpha = 2; elaboration only
    function automatic gen_t gen_poly(input int npar);
        gen_t g;
        sym_t root;
        g = '0;
        g[0] = 8'h01;
        root = 8'h01;
        for (int i = 1; i <= npar; i++)
        begin
            root = gf_mul(root, 8'h02);
            for (int j = i; j > 0; j--)
            begin
                g[j] = g[j-1] ^ gf_mul(g[j], root);
            end
            g[0] = gf_mul(g[0], root);
        end
        return g;
    endfunction

endpackage

// ===== hdl/rsse_ctrl.sv =====
module rsse_ctrl
    import rsse_pkg::*;
#(
    parameter int NPAR = 223
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic kind,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    localparam int CNT_W = $clog2(NPAR + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NPAR - 1);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic accept;
    logic final_sym;

    // Output register bookkeeping
    always_comb
    begin
        in_stall  = (state_reg == ST_FULL) && out_stall;
        out_valid = (state_reg == ST_FULL);
    end

    assign accept    = in_valid && !in_stall;
    assign final_sym = kind && (count_reg == LAST_CNT);

    // Next state
    always_comb
    begin
        case (state_reg)
            ST_EMPTY:
            begin
                state_next = accept ? ST_FULL : ST_EMPTY;
            end
            ST_FULL:
            begin
                if (!out_stall)
                begin
                    state_next = accept ? ST_FULL : ST_EMPTY;
                end
                else
                begin
                    state_next = ST_FULL;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd.take   = accept;
        cmd.parity = kind;
        cmd.last   = final_sym;
    end

    // Parity octets emitted in the current codeword
    always_comb
    begin
        count_next = count_reg;
        if (accept && kind)
        begin
            count_next = final_sym ? '0 : count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Counter never reaches the parity length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_CNT)
        else $error("parity count out of range");

    // Closing parity octet restarts the count
    a_count_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && cmd.last |=> count_reg == '0)
        else $error("parity count not cleared after last");

    // Input is held off only behind a full output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output register");

    // Information symbols leave the count alone
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && !cmd.parity |=> $stable(count_reg))
        else $error("count moved on information symbol");

endmodule

// ===== hdl/rsse_datapath.sv =====
module rsse_datapath
    import rsse_pkg::*;
#(
    parameter int NPAR = 223
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  sym_t data_symbol,
    output sym_t code_symbol,
    output logic is_parity,
    output logic last
);

    localparam gen_t GEN = gen_poly(NPAR);

    sym_t par_reg [NPAR];
    sym_t par_next [NPAR];
    sym_t fb;
    sym_t top;
    sym_t code_symbol_reg;
    logic is_parity_reg;
    logic last_reg;

    assign top = par_reg[NPAR-1];
    assign fb  = data_symbol ^ top;

    // LFSR division stage: constant GF multipliers per tap
    assign par_next[0] = cmd.parity ? '0 : gf_mul(fb, GEN[0]);

    for (genvar j = 1; j < NPAR; j++)
    begin : g_tap
        assign par_next[j] = cmd.parity ? par_reg[j-1]
                                        : par_reg[j-1] ^ gf_mul(fb, GEN[j]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NPAR; j++)
            begin
                par_reg[j] <= '0;
            end
        end
        else if (cmd.take)
        begin
            for (int j = 0; j < NPAR; j++)
            begin
                par_reg[j] <= par_next[j];
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            code_symbol_reg <= cmd.parity ? top : data_symbol;
            is_parity_reg   <= cmd.parity;
            last_reg        <= cmd.parity && cmd.last;
        end
    end

    assign code_symbol = code_symbol_reg;
    assign is_parity   = is_parity_reg;
    assign last        = last_reg;

    // With a single parity octet, the remainder register is empty after the closing parity octet
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && cmd.parity && cmd.last && NPAR == 1 |=> par_reg[0] == '0)
        else $error("remainder not cleared after last parity");

    // Parity shift moves the register up by one octet
    a_parity_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && cmd.parity |=> par_reg[0] == '0)
        else $error("parity shift did not fill with zero");

    // Echoed symbols come out unchanged
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && !cmd.parity |=> code_symbol_reg == $past(data_symbol))
        else $error("information symbol not echoed");

endmodule

// ===== hdl/reed_solomon_systematic_encoder_core.sv =====
// Systematic RS encoder over GF(256), generator roots alpha^1..alpha^P.
// A result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle while out_stall does not hold a full output register;
// the parallel LFSR with constant GF multipliers updates all P remainder octets together.
// Reset (async, rst_n low) clears the remainder register, parity count and output valid.
module reed_solomon_systematic_encoder_core
    import rsse_pkg::*;
#(
    parameter int CODE_LENGTH  = 255,
    parameter int DATA_SYMBOLS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] data_symbol,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] code_symbol,
    output logic       is_parity,
    output logic       last
);

    // Parity length; at least one octet
    localparam int NPAR = (CODE_LENGTH > DATA_SYMBOLS) ? CODE_LENGTH - DATA_SYMBOLS : 1;

    cmd_t cmd;

    rsse_ctrl #(
        .NPAR (NPAR)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    rsse_datapath #(
        .NPAR (NPAR)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_symbol (data_symbol),
        .code_symbol (code_symbol),
        .is_parity   (is_parity),
        .last        (last)
    );

endmodule
